@@ rtl/core/ppi_pkg.sv @@
// Shared types, codes and arithmetic helpers of the particle pool integrator.
package ppi_pkg;

  localparam int unsigned POOL_SIZE_DEF = 128;

  typedef enum logic [1:0] {
    ACT_SPAWN = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef struct packed {
    logic               alive;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic        [23:0] age;
    logic        [23:0] life;
    logic signed [31:0] grav;
    logic        [23:0] drag;
  } part_t;

  localparam int unsigned PART_W = $bits(part_t);

  localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SAT_MIN = 34'sh3_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Rounds a Q.32 product to Q.16, ties toward plus infinity.
  function automatic logic signed [31:0] rnd16(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + 48'sd32768;
    return t[47:16];
  endfunction

  // Rounds a product with a Q0.32 factor back to the original scale.
  function automatic logic signed [31:0] rnd32(input logic signed [64:0] v);
    logic signed [64:0] t;
    t = v + 65'sh0_8000_0000;
    return t[63:32];
  endfunction

endpackage

@@ rtl/core/ppi_if.sv @@
// Beat interfaces for the request and result channels of the particle pool.
interface ppi_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic        [6:0]  slot_index;
  logic signed [31:0] spawn_x;
  logic signed [31:0] spawn_y;
  logic signed [31:0] spawn_vx;
  logic signed [31:0] spawn_vy;
  logic        [23:0] spawn_life;
  logic signed [31:0] spawn_gravity;
  logic        [23:0] spawn_drag;
  logic        [15:0] tick_dt;

  modport source (output valid, action, slot_index, spawn_x, spawn_y, spawn_vx, spawn_vy,
                  spawn_life, spawn_gravity, spawn_drag, tick_dt, input ready);
  modport sink (input valid, action, slot_index, spawn_x, spawn_y, spawn_vx, spawn_vy,
                spawn_life, spawn_gravity, spawn_drag, tick_dt, output ready);
endinterface

interface ppi_out_if;
  logic               valid;
  logic               ready;
  logic        [6:0]  slot_used;
  logic               slot_alive;
  logic signed [31:0] read_x;
  logic signed [31:0] read_y;
  logic        [23:0] read_age;
  logic        [7:0]  live_count;

  modport source (output valid, slot_used, slot_alive, read_x, read_y, read_age, live_count,
                  input ready);
  modport sink (input valid, slot_used, slot_alive, read_x, read_y, read_age, live_count,
                output ready);
endinterface

@@ rtl/core/particle_pool_integrator.sv @@
// Particle pool integrator top level.
// All particle state, including the live flag, sits in one memory of POOL_SIZE words
// with one read and one write port. Spawn and read each pass through a state of
// their own before returning to idle; a paused tick is answered from idle. A tick
// walks the pool through the memory read port, one slot per cycle, into a six-stage
// update pipeline: it issues every slot, drains the pipeline and then posts the
// result. Clear sweeps the memory and then posts its result. After reset the same
// sweep runs before the first beat is taken. A new request is taken while the
// previous result beat leaves.
module particle_pool_integrator #(
  parameter int unsigned POOL_SIZE = ppi_pkg::POOL_SIZE_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ppi_in_if.sink    in_i,
  ppi_out_if.source out_o
);
  import ppi_pkg::*;

  localparam int unsigned IW = $clog2(POOL_SIZE);
  localparam int unsigned CW = $clog2(POOL_SIZE + 1);
  localparam logic [IW-1:0] LAST = IW'(POOL_SIZE - 1);

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SPAWN = 6'b000100,
    ST_READ  = 6'b001000,
    ST_TICK  = 6'b010000,
    ST_CLEAR = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [IW-1:0] idx_q, idx_d, next_q, next_d;
  logic [CW-1:0] live_q, live_d;
  logic issued_q, issued_d;
  logic inrange_q, inrange_d;
  part_t spawn_q;
  logic [15:0] dt_q;
  logic [IW-1:0] rslot_q;

  logic we;
  logic [IW-1:0] waddr, raddr;
  part_t wdata, rdata;

  ppi_ram #(.WIDTH(PART_W), .DEPTH(POOL_SIZE)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  // Update pipeline.
  logic rd_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic [IW-1:0] rd_a_q, s1_a_q, s2_a_q, s3_a_q, s4_a_q, s5_a_q;
  part_t s1_w_q, s2_w_q, s3_w_q, s4_w_q, s5_w_q, s5_out;
  part_t s1_w_d, s2_w_d, s4_w_d;
  logic s1_die_q, s2_die_q, s3_die_q, s4_die_q, s5_die_q;
  logic signed [47:0] s1_gdt_q, s5_px_q, s5_py_q;
  logic [39:0] s1_p_q;
  logic [31:0] s2_k_q;
  logic s2_one_q, s3_one_q;
  logic signed [64:0] s3_mx_q, s3_my_q;
  logic [24:0] age_sum;
  logic [23:0] age_new;

  assign age_sum = {1'b0, rdata.age} + 25'(dt_q);
  assign age_new = age_sum[24] ? 24'hFF_FFFF : age_sum[23:0];

  always_comb begin
    s1_w_d = rdata;
    s1_w_d.age = age_new;
    s2_w_d = s1_w_q;
    s2_w_d.vy = sat32(34'(s1_w_q.vy) + 34'(rnd16(s1_gdt_q)));
    s4_w_d = s3_w_q;
    if (!s3_one_q) begin
      s4_w_d.vx = rnd32(s3_mx_q);
      s4_w_d.vy = rnd32(s3_my_q);
    end
  end

  always_comb begin
    s5_out = s5_w_q;
    s5_out.x = sat32(34'(s5_w_q.x) + 34'(rnd16(s5_px_q)));
    s5_out.y = sat32(34'(s5_w_q.y) + 34'(rnd16(s5_py_q)));
    if (s5_die_q) begin
      s5_out.alive = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      rd_v_q <= (state_q == ST_TICK) && !issued_q;
      s1_v_q <= rd_v_q && rdata.alive;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= idx_q;
    s1_a_q <= rd_a_q;
    s1_w_q <= s1_w_d;
    s1_die_q <= age_new >= rdata.life;
    s1_gdt_q <= 48'(rdata.grav * $signed({1'b0, dt_q}));
    s1_p_q <= 40'(rdata.drag) * 40'(dt_q);

    s2_a_q <= s1_a_q;
    s2_w_q <= s2_w_d;
    s2_die_q <= s1_die_q;
    s2_one_q <= s1_p_q == 40'd0;
    s2_k_q <= (s1_p_q[39:32] == 8'd0) ? (32'd0 - s1_p_q[31:0]) : 32'd0;

    s3_a_q <= s2_a_q;
    s3_w_q <= s2_w_q;
    s3_die_q <= s2_die_q;
    s3_one_q <= s2_one_q;
    s3_mx_q <= 65'(s2_w_q.vx * $signed({1'b0, s2_k_q}));
    s3_my_q <= 65'(s2_w_q.vy * $signed({1'b0, s2_k_q}));

    s4_a_q <= s3_a_q;
    s4_w_q <= s4_w_d;
    s4_die_q <= s3_die_q;

    s5_a_q <= s4_a_q;
    s5_w_q <= s4_w_q;
    s5_die_q <= s4_die_q;
    s5_px_q <= 48'(s4_w_q.vx * $signed({1'b0, dt_q}));
    s5_py_q <= 48'(s4_w_q.vy * $signed({1'b0, dt_q}));
  end

  // Control.
  logic in_fire, out_take, pipe_busy;
  logic out_set;
  logic [6:0] o_slot;
  logic o_alive;

  assign in_i.ready = (state_q == ST_IDLE) && (!out_o.valid || out_o.ready);
  assign in_fire = in_i.valid && in_i.ready;
  assign out_take = out_o.valid && out_o.ready;
  assign pipe_busy = rd_v_q || s1_v_q || s2_v_q || s3_v_q || s4_v_q || s5_v_q;

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    next_d = next_q;
    live_d = live_q;
    issued_d = issued_q;
    inrange_d = inrange_q;
    out_set = 1'b0;
    o_slot = 7'd0;
    o_alive = 1'b0;
    we = 1'b0;
    waddr = idx_q;
    wdata = '0;
    raddr = idx_q;
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST) begin
          idx_d = '0;
          state_d = ST_IDLE;
          out_set = state_q == ST_CLEAR;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (action_e'(in_i.action))
            ACT_SPAWN: begin
              raddr = next_q;
              state_d = ST_SPAWN;
            end
            ACT_TICK: begin
              if (in_i.tick_dt == 16'd0) begin
                out_set = 1'b1;
              end else begin
                idx_d = '0;
                issued_d = 1'b0;
                state_d = ST_TICK;
              end
            end
            ACT_CLEAR: begin
              idx_d = '0;
              next_d = '0;
              live_d = '0;
              state_d = ST_CLEAR;
            end
            ACT_READ: begin
              raddr = IW'(in_i.slot_index);
              inrange_d = 32'(in_i.slot_index) < POOL_SIZE;
              state_d = ST_READ;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SPAWN: begin
        we = 1'b1;
        waddr = next_q;
        wdata = spawn_q;
        if (!rdata.alive) begin
          live_d = live_q + 1'b1;
        end
        next_d = (next_q == LAST) ? '0 : next_q + 1'b1;
        out_set = 1'b1;
        o_slot = 7'(next_q);
        state_d = ST_IDLE;
      end
      ST_READ: begin
        out_set = 1'b1;
        o_slot = 7'(rslot_q);
        o_alive = inrange_q && rdata.alive;
        state_d = ST_IDLE;
      end
      ST_TICK: begin
        if (!issued_q) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == LAST) begin
            idx_d = '0;
            issued_d = 1'b1;
          end
        end else if (!pipe_busy) begin
          out_set = 1'b1;
          state_d = ST_IDLE;
        end
        if (s5_v_q) begin
          we = 1'b1;
          waddr = s5_a_q;
          wdata = s5_out;
          if (s5_die_q) begin
            live_d = live_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  logic out_valid_q;
  assign out_o.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      idx_q <= '0;
      next_q <= '0;
      live_q <= '0;
      issued_q <= 1'b0;
      inrange_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      next_q <= next_d;
      live_q <= live_d;
      issued_q <= issued_d;
      inrange_q <= inrange_d;
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      spawn_q.alive <= 1'b1;
      spawn_q.x <= in_i.spawn_x;
      spawn_q.y <= in_i.spawn_y;
      spawn_q.vx <= in_i.spawn_vx;
      spawn_q.vy <= in_i.spawn_vy;
      spawn_q.age <= '0;
      spawn_q.life <= in_i.spawn_life;
      spawn_q.grav <= in_i.spawn_gravity;
      spawn_q.drag <= in_i.spawn_drag;
      dt_q <= in_i.tick_dt;
      rslot_q <= IW'(in_i.slot_index);
    end
    if (out_set) begin
      out_o.slot_used <= o_slot;
      out_o.slot_alive <= o_alive;
      out_o.read_x <= o_alive ? rdata.x : 32'sd0;
      out_o.read_y <= o_alive ? rdata.y : 32'sd0;
      out_o.read_age <= o_alive ? rdata.age : 24'd0;
      out_o.live_count <= 8'(live_d);
    end
  end
endmodule

@@ rtl/core/ppi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ppi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ rtl/core/ppi_checker.sv @@
// Port-level checks of the particle pool integrator and their binding.
module ppi_port_checks #(
  parameter int unsigned POOL_SIZE = ppi_pkg::POOL_SIZE_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [6:0]  slot_used_i,
  input logic        slot_alive_i,
  input logic [31:0] read_x_i,
  input logic [31:0] read_y_i,
  input logic [23:0] read_age_i,
  input logic [7:0]  live_count_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_dead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !slot_alive_i |->
      (read_x_i == 32'd0 && read_y_i == 32'd0 && read_age_i == 24'd0))
    else $error("dead slot reported with data");

  a_alive_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && slot_alive_i |-> live_count_i != 8'd0)
    else $error("live slot reported with zero live count");

  a_alive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && slot_alive_i |-> 32'(slot_used_i) < POOL_SIZE)
    else $error("live slot outside the pool");
endmodule

bind particle_pool_integrator ppi_port_checks #(.POOL_SIZE(POOL_SIZE)) u_ppi_port_checks (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .slot_used_i(out_o.slot_used),
  .slot_alive_i(out_o.slot_alive),
  .read_x_i(out_o.read_x),
  .read_y_i(out_o.read_y),
  .read_age_i(out_o.read_age),
  .live_count_i(out_o.live_count)
);

@@ tb/ppi_checker.sv @@
// Checker that predicts every result beat of the particle pool and compares it.
module ppi_checker (
  input  logic     clk_i,
  input  logic     rst_ni,
  ppi_in_if.sink   req_i,
  ppi_out_if.sink  res_i,
  output int       fail_count_o,
  output int       pending_o,
  output int       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppi_pkg::*;

  localparam int unsigned SLOTS = POOL_SIZE_DEF;

  typedef struct packed {
    logic        [6:0]  slot_used;
    logic               slot_alive;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [23:0] age;
    logic        [7:0]  live;
  } result_t;

  logic signed [31:0] px [SLOTS];
  logic signed [31:0] py [SLOTS];
  logic signed [31:0] vx [SLOTS];
  logic signed [31:0] vy [SLOTS];
  logic        [23:0] age [SLOTS];
  logic        [23:0] life [SLOTS];
  logic signed [31:0] grav [SLOTS];
  logic        [23:0] drag [SLOTS];
  logic               alive [SLOTS];
  logic        [6:0]  ring_ptr;
  int                 live_total;
  result_t            expected_results [$];
  int                 fails;
  int                 checked;

  assign fail_count_o = fails;
  assign pending_o = expected_results.size();
  assign checked_o = checked;

  function automatic longint round_down(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  task automatic integrate(logic [15:0] dt);
    longint a, p, k, nvx, nvy;
    for (int i = 0; i < SLOTS; i++) begin
      if (alive[i]) begin
        a = longint'(age[i]) + longint'(dt);
        if (a > 64'hFF_FFFF) a = 64'hFF_FFFF;
        age[i] = a[23:0];
        if (age[i] >= life[i]) begin
          alive[i] = 1'b0;
          live_total--;
        end else begin
          nvy = clamp32(longint'(vy[i]) + round_down(longint'(grav[i]) * longint'(dt), 16));
          p = longint'(drag[i]) * longint'(dt);
          k = (p < (longint'(1) << 32)) ? ((longint'(1) << 32) - p) : 0;
          nvx = longint'(vx[i]);
          if (k < (longint'(1) << 32)) begin
            nvx = round_down(nvx * k, 32);
            nvy = round_down(nvy * k, 32);
          end
          vx[i] = nvx[31:0];
          vy[i] = nvy[31:0];
          px[i] = clamp32(longint'(px[i]) + round_down(longint'(vx[i]) * longint'(dt), 16));
          py[i] = clamp32(longint'(py[i]) + round_down(longint'(vy[i]) * longint'(dt), 16));
        end
      end
    end
  endtask

  task automatic predict_beat();
    result_t r;
    int s;
    r = '0;
    case (action_e'(req_i.action))
      ACT_SPAWN: begin
        s = ring_ptr;
        if (!alive[s]) live_total++;
        px[s] = req_i.spawn_x;
        py[s] = req_i.spawn_y;
        vx[s] = req_i.spawn_vx;
        vy[s] = req_i.spawn_vy;
        life[s] = req_i.spawn_life;
        grav[s] = req_i.spawn_gravity;
        drag[s] = req_i.spawn_drag;
        age[s] = '0;
        alive[s] = 1'b1;
        ring_ptr = ring_ptr + 7'd1;
        r.slot_used = s[6:0];
      end
      ACT_TICK: begin
        if (req_i.tick_dt != 16'd0) integrate(req_i.tick_dt);
      end
      ACT_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) alive[i] = 1'b0;
        ring_ptr = '0;
        live_total = 0;
      end
      default: begin
        s = req_i.slot_index;
        r.slot_used = req_i.slot_index;
        if (alive[s]) begin
          r.slot_alive = 1'b1;
          r.x = px[s];
          r.y = py[s];
          r.age = age[s];
        end
      end
    endcase
    r.live = live_total[7:0];
    expected_results.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) alive[i] = 1'b0;
      ring_ptr = '0;
      live_total = 0;
      expected_results.delete();
      fails = 0;
      checked = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got = {res_i.slot_used, res_i.slot_alive, res_i.read_x, res_i.read_y,
               res_i.read_age, res_i.live_count};
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10) $display("result beat with nothing expected: %p", got);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got !== want) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      if (req_i.valid && req_i.ready) predict_beat();
    end
  end
endmodule

@@ tb/testbench.sv @@
// Top of the testbench: clock, reset, request stimulus, result stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ppi_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, checked;
  int   send_idle_pct = 17;
  int   recv_idle_pct = 88;
  int   quiet_cycles = 0;
  int   n_spawn = 0, n_tick = 0, n_clear = 0, n_read = 0;

  ppi_in_if  req_if ();
  ppi_out_if res_if ();

  particle_pool_integrator dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_if), .out_o(res_if));

  ppi_checker chk (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if), .res_i(res_if),
                   .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked));

  always #6 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.action = ACT_READ;
    req_if.slot_index = '0;
    req_if.spawn_x = '0;
    req_if.spawn_y = '0;
    req_if.spawn_vx = '0;
    req_if.spawn_vy = '0;
    req_if.spawn_life = '0;
    req_if.spawn_gravity = '0;
    req_if.spawn_drag = '0;
    req_if.tick_dt = '0;
    res_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(action_e act, logic [6:0] idx, logic [31:0] x, logic [31:0] y,
                      logic [31:0] svx, logic [31:0] svy, logic [23:0] lf,
                      logic [31:0] g, logic [23:0] dr, logic [15:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.slot_index <= idx;
    req_if.spawn_x <= x;
    req_if.spawn_y <= y;
    req_if.spawn_vx <= svx;
    req_if.spawn_vy <= svy;
    req_if.spawn_life <= lf;
    req_if.spawn_gravity <= g;
    req_if.spawn_drag <= dr;
    req_if.tick_dt <= dt;
    do @(posedge clk_i); while (!req_if.ready);
    case (act)
      ACT_SPAWN: n_spawn++;
      ACT_TICK:  n_tick++;
      ACT_CLEAR: n_clear++;
      default:   n_read++;
    endcase
  endtask

  task automatic random_beat();
    int r;
    logic [23:0] lf, dr;
    logic [15:0] dt;
    r = $urandom_range(99);
    lf = ($urandom_range(9) == 0) ? 24'($urandom) : 24'hFF_FFFF - 24'($urandom_range(4095));
    dr = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(65535));
    dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2047));
    if ($urandom_range(19) == 0) dt = '0;
    if ($urandom_range(29) == 0) lf = '0;
    if (r < 45) send(ACT_SPAWN, 7'($urandom), pick32(), pick32(), pick32(), pick32(),
                     lf, pick32(), dr, 16'($urandom));
    else if (r < 60) send(ACT_TICK, 7'($urandom), $urandom, $urandom, $urandom, $urandom,
                          24'($urandom), $urandom, 24'($urandom), dt);
    else if (r < 61) send(ACT_CLEAR, 7'($urandom), $urandom, $urandom, $urandom, $urandom,
                          24'($urandom), $urandom, 24'($urandom), 16'($urandom));
    else send(ACT_READ, 7'($urandom), $urandom, $urandom, $urandom, $urandom,
              24'($urandom), $urandom, 24'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(ACT_READ, 7'd0, '0, '0, '0, '0, '0, '0, '0, '0);
    send(ACT_SPAWN, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
         24'hFF_FFFF, 32'h7FFF_FFFF, 24'h0, '0);
    send(ACT_SPAWN, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
         24'hFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, '0);
    send(ACT_SPAWN, '0, '0, '0, 32'h0001_0000, 32'hFFFF_0000, 24'h0, 32'h0, 24'h0, '0);
    send(ACT_SPAWN, '0, 32'h0010_0000, 32'h0010_0000, 32'h0001_8000, 32'hFFFE_8000,
         24'h02_0000, 32'h0009_8000, 24'h00_8000, '0);
    send(ACT_TICK, 7'h7F, '0, '0, '0, '0, '0, '0, '0, 16'h0000);
    for (int i = 0; i < 5; i++)
      send(ACT_READ, 7'(i), '0, '0, '0, '0, '0, '0, '0, '0);
    send(ACT_TICK, '0, '0, '0, '0, '0, '0, '0, '0, 16'hFFFF);
    for (int i = 0; i < 5; i++)
      send(ACT_READ, 7'(i), '0, '0, '0, '0, '0, '0, '0, '0);
    send(ACT_READ, 7'h7F, '0, '0, '0, '0, '0, '0, '0, '0);
    send(ACT_TICK, '0, '0, '0, '0, '0, '0, '0, '0, 16'h0001);
    send(ACT_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    send(ACT_READ, 7'd1, '0, '0, '0, '0, '0, '0, '0, '0);

    for (int n = 0; n < 2000; n++) begin
      if (n == 700) begin
        send_idle_pct = 88;
        recv_idle_pct = 17;
      end else if (n == 1400) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_beat();
    end
    req_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("covered %0d spawns, %0d ticks, %0d clears and %0d reads;", n_spawn, n_tick,
             n_clear, n_read);
    $display("%0d result beats compared, %0d failures", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
